// ===== rtl/core/crbc_pkg.sv =====
// Shared constants, types and address helpers for the cartridge bank controller.
package crbc_pkg;

  localparam int ROM_ADDR_BITS  = 19;
  localparam int RAM_BANKS      = 4;
  localparam int ROM_DEPTH      = 2 ** ROM_ADDR_BITS;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_ADDR_BITS  = $clog2(RAM_DEPTH);

  localparam int CQ_DEPTH     = 4;
  localparam int CQ_PTR_BITS  = $clog2(CQ_DEPTH);
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd1;
  localparam logic [1:0] ST_RAM_DISABLED = 2'd2;

  localparam logic [15:0] ENABLE_END    = 16'h1fff;
  localparam logic [15:0] ROM0_END      = 16'h3fff;
  localparam logic [15:0] HIGH_BITS_END = 16'h5fff;
  localparam logic [15:0] ROMX_END      = 16'h7fff;
  localparam logic [15:0] RAM_START     = 16'ha000;
  localparam logic [15:0] RAM_END       = 16'hbfff;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'ha;
  localparam logic [7:0] IDLE_BYTE      = 8'hff;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ROM_READ,
    CMD_RAM_READ,
    CMD_ROM_WRITE,
    CMD_RAM_WRITE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [ROM_ADDR_BITS-1:0] rom_addr;
    logic [RAM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]               data;
    logic [1:0]               status;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // bank modulo RAM_BANKS on a two-bit value
  function automatic logic [1:0] ram_bank_wrap(input logic [1:0] bank);
    logic [2:0] v;
    v = {1'b0, bank};
    for (int i = 0; i < 3; i++) begin
      if (v >= 3'(RAM_BANKS)) v = v - 3'(RAM_BANKS);
    end
    return v[1:0];
  endfunction

  function automatic logic [ROM_ADDR_BITS-1:0] rom_addr_of(input logic [6:0] bank,
                                                           input logic [13:0] offset);
    logic [20:0] flat;
    flat = {bank, offset};
    return flat[ROM_ADDR_BITS-1:0];
  endfunction

  function automatic logic [RAM_ADDR_BITS-1:0] ram_addr_of(input logic [1:0] bank,
                                                           input logic [12:0] offset);
    logic [14:0] flat;
    flat = {bank, offset};
    return flat[RAM_ADDR_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/crbc_ram.sv =====
// Generic single-port RAM with registered read.
module crbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/crbc_cmd_queue.sv =====
// Command queue between the decode front and the memory back end.
module crbc_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  crbc_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output crbc_pkg::cmd_t cmd_out,
  output logic           empty
);

  crbc_pkg::cmd_t                   entries [crbc_pkg::CQ_DEPTH];
  logic [crbc_pkg::CQ_PTR_BITS-1:0] wr_ptr;
  logic [crbc_pkg::CQ_PTR_BITS-1:0] rd_ptr;
  logic [crbc_pkg::CQ_PTR_BITS:0]   count;
  logic [crbc_pkg::CQ_PTR_BITS:0]   count_next;

  assign full    = count == (crbc_pkg::CQ_PTR_BITS + 1)'(crbc_pkg::CQ_DEPTH);
  assign empty   = count == '0;
  assign cmd_out = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= cmd_in;
  end

endmodule

// ===== rtl/core/crbc_front.sv =====
// Front end: accepts bus words, keeps the bank registers, decodes into commands.
module crbc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          operation,
  input  logic [15:0]         bus_address,
  input  logic [7:0]          write_data,
  input  logic [18:0]         load_address,
  input  logic                cq_full,
  input  crbc_pkg::back_stat_t back_stat,
  output logic                full,
  output logic                cq_push,
  output crbc_pkg::cmd_t      cq_cmd
);

  logic [4:0]  bank_low_bits;
  logic [4:0]  bank_low_bits_next;
  logic [1:0]  bank_high_bits;
  logic [1:0]  bank_high_bits_next;
  logic        ram_mode;
  logic        ram_mode_next;
  logic        ram_enable;
  logic        ram_enable_next;
  logic [6:0]  rom_sel;
  logic [1:0]  ram_bank;
  logic [20:0] load_flat;

  assign full    = cq_full | back_stat.clearing;
  assign cq_push = push & ~full;

  assign rom_sel   = ram_mode ? {2'b00, bank_low_bits} : {bank_high_bits, bank_low_bits};
  assign ram_bank  = crbc_pkg::ram_bank_wrap(ram_mode ? bank_high_bits : 2'b00);
  assign load_flat = 21'(load_address);

  always_comb begin
    bank_low_bits_next  = bank_low_bits;
    bank_high_bits_next = bank_high_bits;
    ram_mode_next       = ram_mode;
    ram_enable_next     = ram_enable;
    cq_cmd.kind     = crbc_pkg::CMD_NONE;
    cq_cmd.rom_addr = crbc_pkg::rom_addr_of(rom_sel, bus_address[13:0]);
    cq_cmd.ram_addr = crbc_pkg::ram_addr_of(ram_bank, bus_address[12:0]);
    cq_cmd.data     = write_data;
    cq_cmd.status   = crbc_pkg::ST_OK;
    case (operation)
      crbc_pkg::OP_READ: begin
        if (bus_address <= crbc_pkg::ROM0_END) begin
          cq_cmd.kind     = crbc_pkg::CMD_ROM_READ;
          cq_cmd.rom_addr = crbc_pkg::rom_addr_of(7'd0, bus_address[13:0]);
        end else if (bus_address <= crbc_pkg::ROMX_END) begin
          cq_cmd.kind = crbc_pkg::CMD_ROM_READ;
        end else if (bus_address >= crbc_pkg::RAM_START &&
                     bus_address <= crbc_pkg::RAM_END) begin
          // RAM reads go through even while RAM is disabled
          cq_cmd.kind = crbc_pkg::CMD_RAM_READ;
        end else begin
          cq_cmd.status = crbc_pkg::ST_OUT_OF_RANGE;
        end
      end
      crbc_pkg::OP_WRITE: begin
        if (bus_address <= crbc_pkg::ENABLE_END) begin
          ram_enable_next = write_data[3:0] == crbc_pkg::RAM_ENABLE_KEY;
        end else if (bus_address <= crbc_pkg::ROM0_END) begin
          bank_low_bits_next = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
        end else if (bus_address <= crbc_pkg::HIGH_BITS_END) begin
          bank_high_bits_next = write_data[1:0];
        end else if (bus_address <= crbc_pkg::ROMX_END) begin
          ram_mode_next = write_data[0];
        end else if (bus_address >= crbc_pkg::RAM_START &&
                     bus_address <= crbc_pkg::RAM_END) begin
          if (ram_enable) cq_cmd.kind = crbc_pkg::CMD_RAM_WRITE;
          else            cq_cmd.status = crbc_pkg::ST_RAM_DISABLED;
        end else begin
          cq_cmd.status = crbc_pkg::ST_OUT_OF_RANGE;
        end
      end
      crbc_pkg::OP_LOAD: begin
        cq_cmd.kind     = crbc_pkg::CMD_ROM_WRITE;
        cq_cmd.rom_addr = load_flat[crbc_pkg::ROM_ADDR_BITS-1:0];
      end
      default: begin
        cq_cmd.kind = crbc_pkg::CMD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_low_bits  <= 5'd1;
      bank_high_bits <= 2'd0;
      ram_mode       <= 1'b0;
      ram_enable     <= 1'b0;
    end else if (cq_push) begin
      bank_low_bits  <= bank_low_bits_next;
      bank_high_bits <= bank_high_bits_next;
      ram_mode       <= ram_mode_next;
      ram_enable     <= ram_enable_next;
    end
  end

endmodule

// ===== rtl/core/crbc_back.sv =====
// Back end: ROM and RAM arrays, RAM clearing pass, result queue.
module crbc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cq_empty,
  input  crbc_pkg::cmd_t       cq_cmd,
  output logic                 cq_pop,
  output crbc_pkg::back_stat_t back_stat,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           read_data,
  output logic [1:0]           status
);

  logic                               clearing;
  logic [crbc_pkg::RAM_ADDR_BITS-1:0] clear_addr;

  logic                               rom_we;
  logic [7:0]                         rom_rdata;
  logic                               ram_we;
  logic [crbc_pkg::RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]                         ram_wdata;
  logic [7:0]                         ram_rdata;

  logic                               s1_valid;
  crbc_pkg::cmd_kind_t                s1_kind;
  logic [1:0]                         s1_status;
  crbc_pkg::result_t                  s1_result;

  crbc_pkg::result_t                  res_entries [crbc_pkg::RES_DEPTH];
  logic [crbc_pkg::RES_PTR_BITS-1:0]  res_wr_ptr;
  logic [crbc_pkg::RES_PTR_BITS-1:0]  res_rd_ptr;
  logic [crbc_pkg::RES_PTR_BITS:0]    res_count;
  logic [crbc_pkg::RES_PTR_BITS:0]    res_count_next;
  logic [crbc_pkg::RES_PTR_BITS+1:0]  res_used;
  logic                               res_pop;

  assign back_stat.clearing = clearing;

  // a word is issued only if its result already has a slot reserved
  assign res_used = (crbc_pkg::RES_PTR_BITS + 2)'(res_count) +
                    (crbc_pkg::RES_PTR_BITS + 2)'(s1_valid);
  assign cq_pop   = ~clearing & ~cq_empty &
                    (res_used < (crbc_pkg::RES_PTR_BITS + 2)'(crbc_pkg::RES_DEPTH));

  assign rom_we    = cq_pop && cq_cmd.kind == crbc_pkg::CMD_ROM_WRITE;
  assign ram_we    = clearing | (cq_pop && cq_cmd.kind == crbc_pkg::CMD_RAM_WRITE);
  assign ram_addr  = clearing ? clear_addr : cq_cmd.ram_addr;
  assign ram_wdata = clearing ? 8'd0 : cq_cmd.data;

  crbc_ram #(
    .WIDTH(8),
    .DEPTH(crbc_pkg::ROM_DEPTH)
  ) u_rom (
    .clk  (clk),
    .we   (rom_we),
    .addr (cq_cmd.rom_addr),
    .wdata(cq_cmd.data),
    .rdata(rom_rdata)
  );

  crbc_ram #(
    .WIDTH(8),
    .DEPTH(crbc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == crbc_pkg::RAM_ADDR_BITS'(crbc_pkg::RAM_DEPTH - 1)) clearing <= 1'b0;
      else clear_addr <= clear_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= cq_pop;
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      s1_kind   <= cq_cmd.kind;
      s1_status <= cq_cmd.status;
    end
  end

  always_comb begin
    s1_result.status = s1_status;
    case (s1_kind)
      crbc_pkg::CMD_ROM_READ: s1_result.read_data = rom_rdata;
      crbc_pkg::CMD_RAM_READ: s1_result.read_data = ram_rdata;
      default:                s1_result.read_data = crbc_pkg::IDLE_BYTE;
    endcase
  end

  assign empty     = res_count == '0;
  assign res_pop   = pop & ~empty;
  assign read_data = res_entries[res_rd_ptr].read_data;
  assign status    = res_entries[res_rd_ptr].status;

  always_comb begin
    case ({s1_valid, res_pop})
      2'b10:   res_count_next = res_count + 1'b1;
      2'b01:   res_count_next = res_count - 1'b1;
      default: res_count_next = res_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (s1_valid) res_wr_ptr <= res_wr_ptr + 1'b1;
      if (res_pop) res_rd_ptr <= res_rd_ptr + 1'b1;
      res_count <= res_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) res_entries[res_wr_ptr] <= s1_result;
  end

endmodule

// ===== rtl/core/cartridge_rom_ram_bank_controller.sv =====
// Cartridge ROM/RAM bank controller: one bus word in, one result word out.
// Path: an accepted word goes through the command queue, the issue register and the result queue.
// Throughput: one word per cycle while results are popped and no clearing pass runs.
// Reset: bank registers return to bank 1, ROM mode, RAM disabled; then a clearing
// pass zeroes all RAM_DEPTH (32768) bytes of cartridge RAM, one byte a cycle, with full high.
module cartridge_rom_ram_bank_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  input  logic [18:0] load_address,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_data,
  output logic [1:0]  status
);

  logic                 cq_push;
  crbc_pkg::cmd_t       cq_in;
  logic                 cq_full;
  logic                 cq_pop;
  crbc_pkg::cmd_t       cq_out;
  logic                 cq_empty;
  crbc_pkg::back_stat_t back_stat;

  crbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .operation   (operation),
    .bus_address (bus_address),
    .write_data  (write_data),
    .load_address(load_address),
    .cq_full     (cq_full),
    .back_stat   (back_stat),
    .full        (full),
    .cq_push     (cq_push),
    .cq_cmd      (cq_in)
  );

  crbc_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cq_push),
    .cmd_in (cq_in),
    .full   (cq_full),
    .pop    (cq_pop),
    .cmd_out(cq_out),
    .empty  (cq_empty)
  );

  crbc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cq_empty (cq_empty),
    .cq_cmd   (cq_out),
    .cq_pop   (cq_pop),
    .back_stat(back_stat),
    .pop      (pop),
    .empty    (empty),
    .read_data(read_data),
    .status   (status)
  );

  // no word can be taken in while RAM is being cleared
  a_full_while_clearing: assert property (@(posedge clk) disable iff (rst)
    back_stat.clearing |-> full)
    else $error("word accepted during RAM clearing pass");

  // nothing is accepted before clearing ends, so no result can be waiting
  a_empty_while_clearing: assert property (@(posedge clk) disable iff (rst)
    back_stat.clearing |-> empty)
    else $error("result present during RAM clearing pass");

  // an accepted word lands in the command queue
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !cq_empty)
    else $error("accepted word missing from command queue");

  // the back end never issues without a queued command
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cq_pop |-> !cq_empty && !back_stat.clearing)
    else $error("command issued from empty queue or during clearing");

endmodule
